FILE: sv/nearest_downscale_grayscale_macros.svh
// Assertion macros for the downscaler RTL.
`ifndef NEAREST_DOWNSCALE_GRAYSCALE_MACROS_SVH
`define NEAREST_DOWNSCALE_GRAYSCALE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NDG_ASSERT_IMPLIES(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("ndg assertion failed: cond implies expr");

// Next-cycle implication, checked on every rising edge outside reset.
`define NDG_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("ndg assertion failed: cond implies expr in the next cycle");

`endif

FILE: sv/ndg_pkg.sv
// Shared types and constants of the nearest-neighbor grayscale downscaler.
package ndg_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_MAX   = 8191;
  localparam int COLOR_W   = 8;
  localparam int COORD_W   = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] RST_IN_WIDTH   = 13'd64;
  localparam logic [CFG_W-1:0] RST_IN_HEIGHT  = 13'd64;
  localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 13'd32;
  localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 13'd32;

  // Decision for the source pixel now at the head of the pipe.
  typedef struct packed {
    logic               hit;
    logic               frame_last;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } sel_t;

endpackage

FILE: sv/ndg_cfg.sv
// Configuration registers and clamping of the frame sizes.
module ndg_cfg #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ndg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ndg_pkg::CFG_W-1:0]     cfg_data,
  output logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                                        iw,
  output logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                                        ih,
  output logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                                        ow,
  output logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                                        oh
);
  import ndg_pkg::*;

  localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
  localparam int DIM_W   = $clog2(EFF_MAX + 1);
  localparam logic [CFG_W-1:0] LIMIT = CFG_W'(EFF_MAX);

  logic [CFG_W-1:0] in_width, in_height, out_width, out_height;
  logic [CFG_W-1:0] iw_c, ih_c, ow_c, oh_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= RST_IN_WIDTH;
      in_height  <= RST_IN_HEIGHT;
      out_width  <= RST_OUT_WIDTH;
      out_height <= RST_OUT_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_WIDTH:   in_width   <= cfg_data;
        CFG_IN_HEIGHT:  in_height  <= cfg_data;
        CFG_OUT_WIDTH:  out_width  <= cfg_data;
        CFG_OUT_HEIGHT: out_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero sizes count as one; inputs saturate at the limit and outputs at the input size.
  always_comb begin
    iw_c = (in_width == '0) ? CFG_W'(1) : ((in_width > LIMIT) ? LIMIT : in_width);
    ih_c = (in_height == '0) ? CFG_W'(1) : ((in_height > LIMIT) ? LIMIT : in_height);
    ow_c = (out_width == '0) ? CFG_W'(1) : ((out_width > iw_c) ? iw_c : out_width);
    oh_c = (out_height == '0) ? CFG_W'(1) : ((out_height > ih_c) ? ih_c : out_height);
  end

  assign iw = DIM_W'(iw_c);
  assign ih = DIM_W'(ih_c);
  assign ow = DIM_W'(ow_c);
  assign oh = DIM_W'(oh_c);

endmodule

FILE: sv/ndg_select.sv
// Source position counters and nearest-neighbor pick logic.
module ndg_select #(
  parameter int MAX_DIM = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                         iw,
  input  logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                         ih,
  input  logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                         ow,
  input  logic [$clog2(((MAX_DIM < ndg_pkg::CFG_MAX) ? MAX_DIM : ndg_pkg::CFG_MAX) + 1)-1:0]
                         oh,
  output ndg_pkg::sel_t  sel
);
  import ndg_pkg::*;

  localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
  localparam int DIM_W   = $clog2(EFF_MAX + 1);
  localparam int CNT_W   = $clog2(EFF_MAX);
  localparam int ACC_W   = $clog2(EFF_MAX * (EFF_MAX + 1) + 1);

  logic [CNT_W-1:0] src_col, src_row, src_col_next, src_row_next;
  logic [DIM_W-1:0] next_out_col, next_out_row, next_out_col_next, next_out_row_next;
  logic [ACC_W-1:0] col_target_acc, row_target_acc, col_target_acc_next, row_target_acc_next;

  logic [ACC_W-1:0] col_lo, col_hi, row_lo, row_hi;
  logic             col_hit, row_hit, row_end, frame_end;

  // The pixel is picked when the accumulator lands in [pos*out, pos*out + out).
  assign col_lo  = ACC_W'(src_col) * ACC_W'(ow);
  assign row_lo  = ACC_W'(src_row) * ACC_W'(oh);
  assign col_hi  = col_lo + ACC_W'(ow);
  assign row_hi  = row_lo + ACC_W'(oh);
  assign col_hit = (next_out_col < ow) && (col_target_acc >= col_lo) && (col_target_acc < col_hi);
  assign row_hit = (next_out_row < oh) && (row_target_acc >= row_lo) && (row_target_acc < row_hi);

  assign row_end   = ((DIM_W + 1)'(src_col) + 1'b1) >= (DIM_W + 1)'(iw);
  assign frame_end = ((DIM_W + 1)'(src_row) + 1'b1) >= (DIM_W + 1)'(ih);

  assign sel.hit        = row_hit && col_hit;
  assign sel.out_x      = COORD_W'(next_out_col);
  assign sel.out_y      = COORD_W'(next_out_row);
  assign sel.frame_last = (((DIM_W + 1)'(next_out_col) + 1'b1) == (DIM_W + 1)'(ow)) &&
                          (((DIM_W + 1)'(next_out_row) + 1'b1) == (DIM_W + 1)'(oh));

  always_comb begin
    src_col_next        = src_col;
    src_row_next        = src_row;
    next_out_col_next   = next_out_col;
    next_out_row_next   = next_out_row;
    col_target_acc_next = col_target_acc;
    row_target_acc_next = row_target_acc;
    if (sel.hit) begin
      next_out_col_next   = next_out_col + 1'b1;
      col_target_acc_next = col_target_acc + ACC_W'(iw);
    end
    if (row_end) begin
      src_col_next        = '0;
      next_out_col_next   = '0;
      col_target_acc_next = '0;
      if (row_hit) begin
        next_out_row_next   = next_out_row + 1'b1;
        row_target_acc_next = row_target_acc + ACC_W'(ih);
      end
      if (frame_end) begin
        src_row_next        = '0;
        next_out_row_next   = '0;
        row_target_acc_next = '0;
      end else begin
        src_row_next = src_row + 1'b1;
      end
    end else begin
      src_col_next = src_col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col        <= '0;
      src_row        <= '0;
      next_out_col   <= '0;
      next_out_row   <= '0;
      col_target_acc <= '0;
      row_target_acc <= '0;
    end else if (advance) begin
      src_col        <= src_col_next;
      src_row        <= src_row_next;
      next_out_col   <= next_out_col_next;
      next_out_row   <= next_out_row_next;
      col_target_acc <= col_target_acc_next;
      row_target_acc <= row_target_acc_next;
    end
  end

endmodule

FILE: sv/nearest_downscale_grayscale.sv
// Top level of the nearest-neighbor downscaler with grayscale conversion.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata = red, green, blue
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata = gray, out_x, out_y; tlast
//  cfg       in         cfg_we (no wait)              cfg_index, cfg_data
//
// One item is accepted per clock while m_axis does not stall; results are registered.
// The pick decision and the gray mean are formed between the input and result registers,
// and a pixel that is not picked produces no item.
// Reset (rst, synchronous) restores the 64x64 to 32x32 default sizes and the first pixel.
// A stall on m_axis holds the result and lets one more pixel wait in the input
// register; s_axis_tready drops only when both registers are held.
`include "nearest_downscale_grayscale_macros.svh"

module nearest_downscale_grayscale #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // Source pixels.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  // Downscaled gray pixels.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // gray[7:0], out_x[19:8], out_y[31:20]
  output logic                          m_axis_tlast,   // frame_last
  // Configuration writes.
  input  logic                          cfg_we,
  input  logic [ndg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ndg_pkg::CFG_W-1:0]     cfg_data
);
  import ndg_pkg::*;

  localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
  localparam int DIM_W   = $clog2(EFF_MAX + 1);
  localparam int SUM_W   = COLOR_W + 2;
  // floor(sum/3) equals (sum*683) >> 11 for every sum of three bytes.
  localparam logic [SUM_W-1:0] DIV3_MUL   = SUM_W'(683);
  localparam int               DIV3_SHIFT = 11;

  logic [DIM_W-1:0] iw, ih, ow, oh;
  sel_t             sel;

  // Input register.
  logic               s1_valid;
  logic [COLOR_W-1:0] s1_red, s1_green, s1_blue;
  logic               advance;

  // Result register.
  logic               out_valid;
  logic [COLOR_W-1:0] out_gray;
  logic [COORD_W-1:0] out_x, out_y;
  logic               out_last;

  logic [SUM_W-1:0]   sum;
  logic [2*SUM_W-1:0] prod;
  logic [COLOR_W-1:0] gray;

  ndg_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .iw        (iw),
    .ih        (ih),
    .ow        (ow),
    .oh        (oh)
  );

  ndg_select #(.MAX_DIM(MAX_DIM)) u_select (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .iw      (iw),
    .ih      (ih),
    .ow      (ow),
    .oh      (oh),
    .sel     (sel)
  );

  // The head pixel moves on whenever the result register is free or being emptied.
  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  assign sum  = SUM_W'(s1_red) + SUM_W'(s1_green) + SUM_W'(s1_blue);
  assign prod = (2*SUM_W)'(sum) * (2*SUM_W)'(DIV3_MUL);
  assign gray = prod[DIV3_SHIFT +: COLOR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_red   <= s_axis_tdata[7:0];
      s1_green <= s_axis_tdata[15:8];
      s1_blue  <= s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= sel.hit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sel.hit) begin
      out_gray <= gray;
      out_x    <= sel.out_x;
      out_y    <= sel.out_y;
      out_last <= sel.frame_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_y, out_x, out_gray};
  assign m_axis_tlast  = out_last;

  // Checks: coordinates stay inside the output frame, the frame mark sits on
  // its last pixel, and the input side stalls only when both registers hold.
  logic x_in_range, y_in_range, last_at_corner, stall_ok;

  assign x_in_range     = CFG_W'(out_x) < CFG_W'(ow);
  assign y_in_range     = CFG_W'(out_y) < CFG_W'(oh);
  assign last_at_corner = ((CFG_W'(out_x) + 1'b1) == CFG_W'(ow)) &&
                          ((CFG_W'(out_y) + 1'b1) == CFG_W'(oh));
  assign stall_ok       = s1_valid && out_valid && !m_axis_tready;

  `NDG_ASSERT_IMPLIES(a_x_in_range, m_axis_tvalid, x_in_range && y_in_range)
  `NDG_ASSERT_IMPLIES(a_last_at_corner, m_axis_tvalid && m_axis_tlast, last_at_corner)
  `NDG_ASSERT_IMPLIES(a_stall_only_when_full, !s_axis_tready, stall_ok)

endmodule

FILE: test/nearest_downscale_grayscale_test.sv
// Self-checking testbench for the nearest-neighbor grayscale downscaler.
module nearest_downscale_grayscale_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ndg_pkg::*;

  // Largest frame side the block is built for; sizes above it are clamped.
  localparam int unsigned DIM_LIMIT = 4096;
  // Source items to send before the run winds down.
  localparam int unsigned ITEM_COUNT = 1650;
  // Cycles without any handshake or register write before the run is given up.
  localparam int unsigned STALL_LIMIT = 1000;
  // The block holds a pixel in its input register and then in its result
  // register, so a pixel that yields nothing can still be in flight after
  // the last gray item. Register writes wait for such a pixel to pass.
  localparam int unsigned PIPE_SETTLE = 4;

  // One downscaled gray pixel as it leaves the block.
  typedef struct {
    logic [COLOR_W-1:0] gray;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               frame_last;
  } gray_pixel_t;

  // Tracks the frame position and size registers of the block, predicts the
  // gray item that each accepted source pixel yields, and checks the items
  // that come out against those predictions in order.
  class gray_scoreboard;
    logic [CFG_W-1:0] in_w_reg, in_h_reg, out_w_reg, out_h_reg;
    logic [11:0]      src_col, src_row;
    logic [12:0]      next_col, next_row;
    logic [24:0]      col_acc, row_acc;
    gray_pixel_t      gray_due_q[$];
    int unsigned      errors;

    function new();
      in_w_reg  = RST_IN_WIDTH;
      in_h_reg  = RST_IN_HEIGHT;
      out_w_reg = RST_OUT_WIDTH;
      out_h_reg = RST_OUT_HEIGHT;
      src_col   = '0;
      src_row   = '0;
      next_col  = '0;
      next_row  = '0;
      col_acc   = '0;
      row_acc   = '0;
      errors    = 0;
    endfunction

    // A size of zero acts as one, and nothing may exceed the upper bound.
    static function int unsigned fit(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // A source position is picked when the next output index, scaled back to
    // source units by the accumulator, falls inside that position's span.
    static function bit on_target(int unsigned pos, int unsigned acc,
                                  int unsigned next, int unsigned n);
      int unsigned lo;
      lo = pos * n;
      return (next < n) && (acc >= lo) && (acc < lo + n);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_IN_WIDTH:   in_w_reg = val;
        CFG_IN_HEIGHT:  in_h_reg = val;
        CFG_OUT_WIDTH:  out_w_reg = val;
        CFG_OUT_HEIGHT: out_h_reg = val;
        default: ;
      endcase
    endfunction

    function void note_source_pixel(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                    logic [COLOR_W-1:0] b);
      int unsigned iw, ih, ow, oh, sum;
      bit          row_hit, col_hit;
      gray_pixel_t px;
      iw = fit(in_w_reg, DIM_LIMIT);
      ih = fit(in_h_reg, DIM_LIMIT);
      // Upscaling is not supported, so the output never outgrows the input.
      ow = fit(out_w_reg, iw);
      oh = fit(out_h_reg, ih);
      row_hit = on_target(src_row, row_acc, next_row, oh);
      col_hit = on_target(src_col, col_acc, next_col, ow);
      if (row_hit && col_hit) begin
        sum           = r + g + b;
        px.gray       = 8'(sum / 3);
        px.out_x      = next_col[11:0];
        px.out_y      = next_row[11:0];
        px.frame_last = (next_col + 1 == ow) && (next_row + 1 == oh);
        gray_due_q.push_back(px);
        next_col = next_col + 13'd1;
        col_acc  = col_acc + 25'(iw);
      end
      // The row ends on its last column, or at once when a smaller width was
      // written while the column counter was already past it.
      if (src_col + 1 >= iw) begin
        src_col  = '0;
        next_col = '0;
        col_acc  = '0;
        // Only a row that was picked moves the output row on.
        if (row_hit) begin
          next_row = next_row + 13'd1;
          row_acc  = row_acc + 25'(ih);
        end
        if (src_row + 1 >= ih) begin
          src_row  = '0;
          next_row = '0;
          row_acc  = '0;
        end else begin
          src_row = src_row + 12'd1;
        end
      end else begin
        src_col = src_col + 12'd1;
      end
    endfunction

    function void check_gray_pixel(logic [31:0] data, logic last);
      gray_pixel_t want;
      if (gray_due_q.size() == 0) begin
        $error("gray item with none expected: gray=%0d out_x=%0d out_y=%0d last=%0b",
               data[7:0], data[19:8], data[31:20], last);
        errors++;
        return;
      end
      want = gray_due_q.pop_front();
      if (data[7:0] !== want.gray) begin
        $error("gray mismatch: expected %0d, actual %0d", want.gray, data[7:0]);
        errors++;
      end
      if (data[19:8] !== want.out_x) begin
        $error("out_x mismatch: expected %0d, actual %0d", want.out_x, data[19:8]);
        errors++;
      end
      if (data[31:20] !== want.out_y) begin
        $error("out_y mismatch: expected %0d, actual %0d", want.out_y, data[31:20]);
        errors++;
      end
      if (last !== want.frame_last) begin
        $error("frame_last mismatch: expected %0b, actual %0b", want.frame_last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return gray_due_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;        // gray[7:0], out_x[19:8], out_y[31:20]
  logic                 m_axis_tlast;        // frame_last
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  gray_scoreboard sb = new();

  // When set, both sides wait a drawn gap before each item.
  bit          bursty = 1'b1;
  // A long receiver hold-off requested by the stimulus, carried out by the
  // receiver process itself after its next item.
  int unsigned hold_cycles = 0;
  int unsigned sent = 0;
  int unsigned quiet_cycles = 0;

  nearest_downscale_grayscale #(
    .MAX_DIM(DIM_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both handshakes are sampled at the rising edge. An item leaving the block
  // always stems from an earlier source pixel, so the order of the two
  // updates below does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_gray_pixel(m_axis_tdata, m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_source_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
      end
    end
  end

  // Any stretch this long without progress means the block has hung or has
  // dropped an expected item.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: waits a drawn number of cycles before taking each item, and
  // now and then holds off long enough for the block to fill up and stall
  // its input.
  initial begin : gray_sink
    int unsigned wait_n;
    forever begin
      if (hold_cycles != 0) begin
        repeat (hold_cycles) @(negedge clk) m_axis_tready <= 1'b0;
        hold_cycles = 0;
      end
      wait_n = bursty ? $urandom_range(0, 4) : 0;
      repeat (wait_n) @(negedge clk) m_axis_tready <= 1'b0;
      @(negedge clk) m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Offers one source pixel after a drawn gap and returns once it is taken.
  // Valid stays high when the next pixel follows without a gap.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    gap = bursty ? $urandom_range(0, 4) : 0;
    repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Random colors, with the component extremes showing up often.
  task automatic send_random(int unsigned count);
    logic [7:0] c[3];
    repeat (count) begin
      foreach (c[k]) begin
        case ($urandom_range(0, 7))
          0:       c[k] = 8'h00;
          1:       c[k] = 8'hFF;
          default: c[k] = 8'($urandom_range(0, 255));
        endcase
      end
      send_pixel(c[0], c[1], c[2]);
    end
  endtask

  // Writes all four size registers. The source side is stopped first and
  // every expected item must have come out, so no pixel is in flight when
  // the sizes change; the frame position carries over.
  task automatic load_sizes(logic [CFG_W-1:0] iw, logic [CFG_W-1:0] ih,
                            logic [CFG_W-1:0] ow, logic [CFG_W-1:0] oh);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_W-1:0]     val[4];
    idx[0] = CFG_IN_WIDTH;
    idx[1] = CFG_IN_HEIGHT;
    idx[2] = CFG_OUT_WIDTH;
    idx[3] = CFG_OUT_HEIGHT;
    val[0] = iw;
    val[1] = ih;
    val[2] = ow;
    val[3] = oh;
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      sb.set_reg(idx[i], val[i]);
    end
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned      phase, kind, n_items;
    bit               hold;
    logic [CFG_W-1:0] iw, ih, ow, oh;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset sizes, 64x64 down to 32x32: every other pixel of the first row
    // is picked. Colors cover the component extremes and the rounding of
    // the mean.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd254);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd85, 8'd170, 8'd85);
    send_pixel(8'd2, 8'd0, 8'd0);

    // All sizes zero act as 1x1: every pixel after the first is a whole frame.
    load_sizes('0, '0, '0, '0);
    send_random(3);

    // Oversized sizes clamp to the limit, so every pixel is picked.
    load_sizes(CFG_W'(CFG_MAX), CFG_W'(CFG_MAX), CFG_W'(CFG_MAX), CFG_W'(CFG_MAX));
    send_random(4);

    // Upscale request clamps the output to the input, and the column counter
    // left past the new width ends the current row at once.
    load_sizes(13'd4, 13'd2, 13'd9, 13'd5);
    send_random(8);

    phase = 0;
    while (sent < ITEM_COUNT) begin
      // Long hold-offs use small frames so that results come early.
      hold = (phase == 0) || ($urandom_range(0, 5) == 0);
      kind = hold ? $urandom_range(2, 11) : $urandom_range(0, 11);
      case (kind)
        0: begin
          // A very wide frame of one or two rows.
          iw = ($urandom_range(0, 1) != 0) ? CFG_W'(CFG_MAX) : CFG_W'(DIM_LIMIT);
          ih = CFG_W'($urandom_range(0, 2));
          case ($urandom_range(0, 2))
            0:       ow = 13'd1;
            1:       ow = CFG_W'(CFG_MAX);
            default: ow = CFG_W'($urandom_range(0, CFG_MAX));
          endcase
          oh = CFG_W'($urandom_range(0, 3));
        end
        1: begin
          // A very tall, narrow frame.
          iw = CFG_W'($urandom_range(0, 3));
          ih = ($urandom_range(0, 1) != 0) ? CFG_W'(CFG_MAX) : CFG_W'(DIM_LIMIT);
          ow = CFG_W'($urandom_range(0, 4));
          case ($urandom_range(0, 2))
            0:       oh = 13'd1;
            1:       oh = CFG_W'(CFG_MAX);
            default: oh = CFG_W'($urandom_range(0, CFG_MAX));
          endcase
        end
        default: begin
          // Small frames, which run through many whole frames, with zero
          // sizes and upscale requests mixed in.
          iw = ($urandom_range(0, 7) == 0) ? '0 : CFG_W'($urandom_range(1, 10));
          ih = ($urandom_range(0, 7) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
          ow = CFG_W'($urandom_range(0, iw + 2));
          oh = CFG_W'($urandom_range(0, ih + 2));
        end
      endcase
      load_sizes(iw, ih, ow, oh);
      bursty = ($urandom_range(0, 3) != 0);
      if (hold) begin
        hold_cycles = $urandom_range(40, 80);
        n_items = $urandom_range(40, 90);
      end else begin
        n_items = $urandom_range(15, 90);
      end
      send_random(n_items);
      phase++;
    end

    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE * 2) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
